/* design/event_hold_activity_output_macros.svh */
// Assertion macros shared by the event hold checker.
`ifndef EVENT_HOLD_ACTIVITY_OUTPUT_MACROS_SVH
`define EVENT_HOLD_ACTIVITY_OUTPUT_MACROS_SVH

// a holds now implies b holds now
`define EHO_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("event hold check failed");

// a holds now implies b holds on the next clock
`define EHO_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("event hold check failed");

`endif

/* design/eho_pkg.sv */
// Shared types and constants of the event hold activity block.
package eho_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int TIME_W         = 32;

    localparam logic [CFG_DATA_W-1:0] HOLD_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] WINDOW_RST = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd1;

    typedef enum logic [1:0] {
        MS_SLEEP    = 2'd0,
        MS_ACTIVATE = 2'd1,
        MS_EXPIRE   = 2'd2,
        MS_WAIT     = 2'd3
    } t_mstate;

    typedef struct packed {
        logic              action;
        logic [7:0]        ev_code;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic       event_output;
        logic [3:0] pending_count;
        logic       add_dropped;
        logic       task_busy;
    } t_result;

    typedef struct packed {
        logic load;
        logic add_step;
        logic idx_inc;
        logic rd;
        logic activate;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic is_add;
        logic ev_zero;
        logic slot_free;
        logic idx_last;
        logic run_skip;
        logic run_activate;
        logic run_wait;
    } t_status;

endpackage

/* design/event_hold_activity_output.sv */
// Add: result strobed straight from decode for event code 0, else once the scan for a free slot ends.
// Run: strobe straight from decode when asleep and empty, else after a scan of every slot (one slot a cycle
// through the time memory's registered read port, then a drain state and the window decision).
// The next request is taken once the controller is back in idle after the strobe; o_busy stays high until then.
// Synchronous active-low reset: table empty, machine asleep, output low, registers at 50/100.
// Results are strobed for one cycle and cannot be stalled.
module event_hold_activity_output #(
    parameter int SLOT_COUNT = eho_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  eho_pkg::t_item                 i_item,
    output logic                           o_strobe,
    output eho_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [eho_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eho_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import eho_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    eho_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    eho_datapath #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

/* design/eho_datapath.sv */
// Datapath: slot table, time memory, counters, config and machine registers.
module eho_datapath #(
    parameter int SLOT_COUNT = eho_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eho_pkg::t_cmd                  i_cmd,
    output eho_pkg::t_status               o_status,
    input  eho_pkg::t_item                 i_item,
    input  logic                           i_cfg_we,
    input  logic [eho_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eho_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output eho_pkg::t_result               o_result
);
    import eho_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

    logic [CFG_DATA_W-1:0] r_hold;
    logic [CFG_DATA_W-1:0] r_window;
    t_mstate               r_mstate;
    logic [TIME_W-1:0]     r_window_start;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [CW-1:0]         r_count;
    logic                  r_output;
    logic                  r_dropped;

    logic                  r_action;
    logic [7:0]            r_ev;
    logic [TIME_W-1:0]     r_now;
    logic [IW-1:0]         r_idx;

    logic [TIME_W-1:0]     r_mem [SLOT_COUNT];
    logic [TIME_W-1:0]     r_rd_time;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_rd_on;

    logic                  add_hit;
    logic                  expire_hit;
    logic [TIME_W-1:0]     age;
    logic [TIME_W-1:0]     elapsed;
    logic [CW+3:0]         count_ext;

    assign add_hit    = i_cmd.add_step && !r_valid[r_idx];
    assign age        = r_now - r_rd_time;
    assign expire_hit = r_rd_on && r_valid[r_rd_idx]
                        && (age >= {{(TIME_W-CFG_DATA_W){1'b0}}, r_hold});
    assign elapsed    = r_now - r_window_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= HOLD_RST;
            r_window <= WINDOW_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_HOLD) begin
                r_hold <= i_cfg_data;
            end else if (i_cfg_index == REG_WINDOW) begin
                r_window <= i_cfg_data;
            end
        end
    end

    // latched request and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_ev     <= i_item.ev_code;
            r_now    <= i_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // slot time memory
    always_ff @(posedge i_clk) begin
        if (add_hit) begin
            r_mem[r_idx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_time <= r_mem[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on <= 1'b0;
        end else begin
            r_rd_on <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (add_hit) begin
            r_valid[r_idx] <= 1'b1;
            r_count        <= r_count + CW'(1);
        end else if (expire_hit) begin
            r_valid[r_rd_idx] <= 1'b0;
            r_count           <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropped <= 1'b0;
        end else if (i_cmd.load) begin
            r_dropped <= 1'b0;
        end else if (i_cmd.add_step && r_valid[r_idx] && (r_idx == IDX_LAST)) begin
            r_dropped <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate       <= MS_SLEEP;
            r_window_start <= '0;
            r_output       <= 1'b0;
        end else if (i_cmd.activate) begin
            r_output       <= 1'b1;
            r_window_start <= r_now;
        end else if (i_cmd.decide) begin
            if (elapsed < {{(TIME_W-CFG_DATA_W){1'b0}}, r_window}) begin
                r_mstate <= MS_EXPIRE;
            end else if (r_count != '0) begin
                r_mstate <= MS_ACTIVATE;
            end else begin
                r_mstate <= MS_SLEEP;
                r_output <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.is_add       = !r_action;
        o_status.ev_zero      = (r_ev == 8'd0);
        o_status.slot_free    = !r_valid[r_idx];
        o_status.idx_last     = (r_idx == IDX_LAST);
        o_status.run_skip     = (r_mstate == MS_SLEEP) && (r_count == '0);
        o_status.run_activate = (r_mstate == MS_SLEEP) || (r_mstate == MS_ACTIVATE);
        o_status.run_wait     = (r_mstate == MS_WAIT);
    end

    assign count_ext = {4'b0000, r_count};

    always_comb begin
        o_result.event_output  = r_output;
        o_result.pending_count = count_ext[3:0];
        o_result.add_dropped   = r_dropped;
        o_result.task_busy     = (r_count != '0) || (r_mstate != MS_SLEEP);
    end

endmodule

/* design/eho_ctrl.sv */
// Controller: sequences add scans, expire scans and the window decision.
module eho_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  eho_pkg::t_status i_status,
    output eho_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);
    import eho_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_WAIT,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DECODE: begin
                o_cmd.activate = !i_status.is_add && !i_status.run_skip
                                 && i_status.run_activate;
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                o_cmd.idx_inc  = !i_status.slot_free && !i_status.idx_last;
            end
            S_SCAN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.idx_inc = !i_status.idx_last;
            end
            S_WAIT: begin
                o_cmd.decide = 1'b1;
            end
            S_DRAIN, S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECODE;
                        r_busy  <= 1'b1;
                    end
                end
                S_DECODE: begin
                    priority if (i_status.is_add && i_status.ev_zero) begin
                        r_state  <= S_RESULT;
                        r_strobe <= 1'b1;
                    end else if (i_status.is_add) begin
                        r_state <= S_ADD;
                    end else if (i_status.run_skip) begin
                        r_state  <= S_RESULT;
                        r_strobe <= 1'b1;
                    end else if (i_status.run_wait) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_ADD: begin
                    if (i_status.slot_free || i_status.idx_last) begin
                        r_state  <= S_RESULT;
                        r_strobe <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (i_status.idx_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state  <= S_RESULT;
                    r_strobe <= 1'b1;
                end
                S_RESULT: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/eho_checker.sv */
// Port-level checker for the event hold activity block, with its bind.
`include "event_hold_activity_output_macros.svh"

module eho_checker #(
    parameter int SLOT_COUNT = eho_pkg::SLOT_COUNT_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_strobe,
    input eho_pkg::t_result o_result
);
    import eho_pkg::*;

    localparam logic [3:0] COUNT_MAX = 4'(SLOT_COUNT);

    `EHO_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `EHO_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `EHO_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_strobe, (SLOT_COUNT > 15) || (o_result.pending_count <= COUNT_MAX))
    `EHO_ASSERT_NOW(a_idle_low, i_clk, i_rst_n, o_strobe && !o_result.task_busy, !o_result.event_output)

endmodule

bind event_hold_activity_output eho_checker #(.SLOT_COUNT(SLOT_COUNT)) u_eho_checker (.*);
